// File: hdl/clt_pkg.sv
// Package for the command line tokenizer: parser state, result word types,
// byte constants and character class functions.
// No dependencies.
package clt_pkg;

  typedef enum logic [3:0] {
    PM_FIRST  = 4'd0,
    PM_DQ     = 4'd1,
    PM_SQ     = 4'd2,
    PM_ARG    = 4'd3,
    PM_DASH   = 4'd4,
    PM_SHORT  = 4'd5,
    PM_DDASH  = 4'd6,
    PM_LONG   = 4'd7,
    PM_EQ     = 4'd8,
    PM_EQDQ   = 4'd9,
    PM_EQSQ   = 4'd10,
    PM_EQARG  = 4'd11
  } parse_mode_t;

  typedef enum logic [1:0] {
    EM_PLAIN = 2'd0,
    EM_DQ    = 2'd1,
    EM_SQ    = 2'd2
  } escape_mode_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_END    = 2'd2
  } act_t;

  localparam logic CFG_ESCAPE = 1'b0;
  localparam logic CFG_WRAP   = 1'b1;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam int RES_MAX = 3;

  typedef struct packed {
    parse_mode_t  pm;
    escape_mode_t em;
    logic         after_bs;
    logic         started;
    logic [7:0]   held_byte;
    logic         held_valid;
  } state_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       token_last;
  } res_t;

  typedef struct packed {
    res_t [RES_MAX-1:0] res;
    logic [1:0]         count;
  } res_set_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_norm(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic logic is_meta(input logic [7:0] c);
    return c == 8'h3C || c == 8'h3E || c == 8'h28 || c == 8'h29 ||
           c == 8'h3B || c == 8'h26 || c == 8'h7C;
  endfunction

endpackage

// File: hdl/clt_step.sv
// One parser step of the tokenizer: next state and up to three result words
// for one input byte. Pure combinational logic.
// Depends on clt_pkg.
module clt_step (
  input  clt_pkg::state_t   st,
  input  logic [7:0]        ch,
  input  logic              escape_enable,
  input  logic              wrap_enable,
  output clt_pkg::state_t   st_next,
  output clt_pkg::res_set_t res_set
);

  clt_pkg::parse_mode_t pm;
  clt_pkg::act_t        act;
  logic [7:0]           gen [3];
  logic [1:0]           gcnt;
  logic [7:0]           seq [4];
  logic [2:0]           slen;
  logic [2:0]           slast;

  always_comb begin
    pm  = st.pm;
    act = clt_pkg::ACT_NONE;
    unique case (st.pm)
      clt_pkg::PM_DQ, clt_pkg::PM_EQDQ: begin
        if (ch == clt_pkg::CH_DQUOTE) begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end else begin
          act = clt_pkg::ACT_APPEND;
        end
      end
      clt_pkg::PM_SQ, clt_pkg::PM_EQSQ: begin
        if (ch == clt_pkg::CH_SQUOTE) begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end else begin
          act = clt_pkg::ACT_APPEND;
        end
      end
      clt_pkg::PM_ARG: begin
        if (clt_pkg::is_blank(ch)) begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end else if (ch != clt_pkg::CH_DQUOTE && ch != clt_pkg::CH_SQUOTE) begin
          act = clt_pkg::ACT_APPEND;
        end
      end
      clt_pkg::PM_DASH: begin
        if (ch == clt_pkg::CH_DASH) begin
          pm  = clt_pkg::PM_DDASH;
          act = clt_pkg::ACT_APPEND;
        end else if (clt_pkg::is_norm(ch)) begin
          pm  = clt_pkg::PM_SHORT;
          act = clt_pkg::ACT_APPEND;
        end else begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end
      end
      clt_pkg::PM_DDASH: begin
        if (clt_pkg::is_norm(ch)) begin
          pm  = clt_pkg::PM_LONG;
          act = clt_pkg::ACT_APPEND;
        end else begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end
      end
      clt_pkg::PM_SHORT, clt_pkg::PM_LONG: begin
        if (clt_pkg::is_norm(ch)) begin
          act = clt_pkg::ACT_APPEND;
        end else if (ch == clt_pkg::CH_EQUAL) begin
          pm  = clt_pkg::PM_EQ;
          act = clt_pkg::ACT_END;
        end else begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end
      end
      clt_pkg::PM_EQ: begin
        if (clt_pkg::is_blank(ch)) begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end else if (ch == clt_pkg::CH_DQUOTE) begin
          pm = clt_pkg::PM_EQDQ;
        end else if (ch == clt_pkg::CH_SQUOTE) begin
          pm = clt_pkg::PM_EQSQ;
        end else begin
          pm  = clt_pkg::PM_EQARG;
          act = clt_pkg::ACT_APPEND;
        end
      end
      clt_pkg::PM_EQARG: begin
        if (clt_pkg::is_blank(ch)) begin
          pm  = clt_pkg::PM_FIRST;
          act = clt_pkg::ACT_END;
        end else begin
          act = clt_pkg::ACT_APPEND;
        end
      end
      default: begin
        if (clt_pkg::is_blank(ch)) begin
          pm = clt_pkg::PM_FIRST;
        end else if (ch == clt_pkg::CH_DASH) begin
          pm  = clt_pkg::PM_DASH;
          act = clt_pkg::ACT_APPEND;
        end else if (ch == clt_pkg::CH_DQUOTE) begin
          pm = clt_pkg::PM_DQ;
        end else if (ch == clt_pkg::CH_SQUOTE) begin
          pm = clt_pkg::PM_SQ;
        end else if (ch == clt_pkg::CH_EQUAL) begin
          pm = clt_pkg::PM_EQ;
        end else begin
          pm  = clt_pkg::PM_ARG;
          act = clt_pkg::ACT_APPEND;
        end
      end
    endcase
    if (ch == clt_pkg::CH_NUL) begin
      pm  = clt_pkg::PM_FIRST;
      act = clt_pkg::ACT_END;
    end
  end

  always_comb begin
    st_next    = st;
    st_next.pm = pm;
    res_set    = '0;
    gen[0]     = clt_pkg::CH_NUL;
    gen[1]     = clt_pkg::CH_NUL;
    gen[2]     = clt_pkg::CH_NUL;
    gcnt       = 2'd0;
    seq[0]     = clt_pkg::CH_NUL;
    seq[1]     = clt_pkg::CH_NUL;
    seq[2]     = clt_pkg::CH_NUL;
    seq[3]     = clt_pkg::CH_NUL;
    slen       = 3'd0;
    slast      = 3'd0;

    if (st.held_valid) begin
      seq[0] = st.held_byte;
      slen   = 3'd1;
    end

    if (act == clt_pkg::ACT_APPEND) begin
      if (!st.started) begin
        st_next.started = 1'b1;
        if (wrap_enable) begin
          gen[gcnt] = clt_pkg::CH_SQUOTE;
          gcnt      = gcnt + 2'd1;
        end
      end
      if (!escape_enable) begin
        st_next.after_bs = 1'b0;
        st_next.em       = clt_pkg::EM_PLAIN;
        gen[gcnt]        = ch;
        gcnt             = gcnt + 2'd1;
      end else if (st.after_bs) begin
        st_next.after_bs = 1'b0;
        gen[gcnt]        = clt_pkg::CH_BACKSLASH;
        gcnt             = gcnt + 2'd1;
        gen[gcnt]        = ch;
        gcnt             = gcnt + 2'd1;
      end else if (ch == clt_pkg::CH_BACKSLASH) begin
        st_next.after_bs = 1'b1;
      end else begin
        unique case (st.em)
          clt_pkg::EM_DQ: begin
            if (ch == clt_pkg::CH_DQUOTE) begin
              st_next.em = clt_pkg::EM_PLAIN;
            end
          end
          clt_pkg::EM_SQ: begin
            if (ch == clt_pkg::CH_SQUOTE) begin
              st_next.em = clt_pkg::EM_PLAIN;
              if (wrap_enable) begin
                gen[gcnt] = clt_pkg::CH_BACKSLASH;
                gcnt      = gcnt + 2'd1;
              end
            end
          end
          default: begin
            if (clt_pkg::is_meta(ch)) begin
              gen[gcnt] = clt_pkg::CH_BACKSLASH;
              gcnt      = gcnt + 2'd1;
            end else if (ch == clt_pkg::CH_DQUOTE) begin
              st_next.em = clt_pkg::EM_DQ;
            end else if (ch == clt_pkg::CH_SQUOTE) begin
              st_next.em = clt_pkg::EM_SQ;
              gen[gcnt]  = clt_pkg::CH_BACKSLASH;
              gcnt       = gcnt + 2'd1;
            end
          end
        endcase
        gen[gcnt] = ch;
        gcnt      = gcnt + 2'd1;
      end

      for (int i = 0; i < clt_pkg::RES_MAX; i++) begin
        if (2'(i) < gcnt) begin
          seq[slen[1:0]] = gen[i];
          slen           = slen + 3'd1;
        end
      end
      if (gcnt != 2'd0) begin
        slast              = slen - 3'd1;
        st_next.held_byte  = seq[slast[1:0]];
        st_next.held_valid = 1'b1;
        res_set.count      = slast[1:0];
        for (int i = 0; i < clt_pkg::RES_MAX; i++) begin
          if (3'(i) < slast) begin
            res_set.res[i] = '{out_char: seq[i], has_char: 1'b1, token_last: 1'b0};
          end
        end
      end
    end else if (act == clt_pkg::ACT_END) begin
      if (st.started) begin
        if (wrap_enable) begin
          seq[slen[1:0]] = clt_pkg::CH_SQUOTE;
          slen           = slen + 3'd1;
        end
        if (slen == 3'd0) begin
          res_set.res[0] = '{out_char: clt_pkg::CH_NUL, has_char: 1'b0, token_last: 1'b1};
          res_set.count  = 2'd1;
        end else begin
          res_set.count = slen[1:0];
          for (int i = 0; i < 2; i++) begin
            if (3'(i) < slen) begin
              res_set.res[i] = '{out_char: seq[i], has_char: 1'b1,
                                 token_last: (3'(i + 1) == slen)};
            end
          end
        end
      end
      st_next.started    = 1'b0;
      st_next.held_byte  = clt_pkg::CH_NUL;
      st_next.held_valid = 1'b0;
      st_next.em         = clt_pkg::EM_PLAIN;
      st_next.after_bs   = 1'b0;
    end
  end

endmodule

// File: hdl/clt_outbuf.sv
// Result buffer of the tokenizer: holds the words of one step and hands
// them out one per handshake. Depends on clt_pkg.
module clt_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  clt_pkg::res_set_t res_set,
  output logic              room,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        out_char,
  output logic              has_char,
  output logic              token_last
);

  clt_pkg::res_t entry [clt_pkg::RES_MAX];
  logic [1:0]    rem;
  logic [1:0]    rd;
  logic          pop;
  clt_pkg::res_t head;

  assign pop          = result_valid && !result_stall;
  assign room         = (rem == 2'd0) || (rem == 2'd1 && pop);
  assign result_valid = rem != 2'd0;
  assign head         = entry[rd];
  assign out_char     = head.out_char;
  assign has_char     = head.has_char;
  assign token_last   = head.token_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      rd  <= 2'd0;
    end else if (load) begin
      rem <= res_set.count;
      rd  <= 2'd0;
    end else if (pop) begin
      rem <= rem - 2'd1;
      rd  <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < clt_pkg::RES_MAX; i++) begin
        entry[i] <= res_set.res[i];
      end
    end
  end

endmodule

// File: hdl/command_line_tokenizer.sv
// Command line tokenizer: an accepted byte is registered, then its result
// words in the result buffer. One byte per cycle while each yields at most one
// word and result_stall is low; a byte that yields more holds the input while
// the one-word result port hands them out (up to three words per byte).
// Synchronous active-high reset: parser between tokens, result buffer
// empty, escape_enable 1, wrap_enable 0. Depends on clt_pkg, clt_step, clt_outbuf.
module command_line_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] ch,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       token_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic       cfg_data
);

  logic              escape_enable;
  logic              wrap_enable;
  logic              in_full;
  logic [7:0]        ch_q;
  logic              room;
  logic              step_go;
  clt_pkg::state_t   st;
  clt_pkg::state_t   st_next;
  clt_pkg::res_set_t res_set;

  assign cfg_ready  = 1'b1;
  assign step_go    = in_full && room;
  assign item_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b1;
      wrap_enable   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == clt_pkg::CFG_ESCAPE) begin
        escape_enable <= cfg_data;
      end else begin
        wrap_enable <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_full <= 1'b1;
    end else if (step_go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      ch_q <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{pm: clt_pkg::PM_FIRST, em: clt_pkg::EM_PLAIN, after_bs: 1'b0,
              started: 1'b0, held_byte: clt_pkg::CH_NUL, held_valid: 1'b0};
    end else if (step_go) begin
      st <= st_next;
    end
  end

  clt_step u_step (
    .st            (st),
    .ch            (ch_q),
    .escape_enable (escape_enable),
    .wrap_enable   (wrap_enable),
    .st_next       (st_next),
    .res_set       (res_set)
  );

  clt_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .load         (step_go),
    .res_set      (res_set),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_char     (out_char),
    .has_char     (has_char),
    .token_last   (token_last)
  );

endmodule
